### sv/score_sort_class_nms_unit_assert.svh
// Assertion macros for the score sort class NMS unit.
// Included by the top level; depends on nothing else.
`ifndef SCORE_SORT_CLASS_NMS_UNIT_ASSERT_SVH
`define SCORE_SORT_CLASS_NMS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SNMS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("snms assertion failed");

// Next-cycle implication.
`define SNMS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("snms assertion failed");

`endif

### sv/snms_pkg.sv
// Shared types, constants and helper functions of the score sort class NMS unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package snms_pkg;

   localparam int MAX_CAND   = 256;
   localparam int IDX_W      = $clog2(MAX_CAND);
   localparam int CNT_W      = IDX_W + 1;
   localparam int MAX_OUT    = 64;
   localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int COORD_W    = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd2;

   typedef struct packed {
      logic        [6:0]  cls;
      logic        [15:0] score;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic        [15:0] width;
      logic        [15:0] height;
   } cand_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      cand_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             overflow;
   } frame_desc_type;

   typedef struct packed {
      logic           valid;
      frame_desc_type desc;
   } queue_if_type;

   typedef struct packed {
      logic active;
      logic pop;
   } back_status_type;

   typedef struct packed {
      logic [7:0]  iou_threshold;
      logic [11:0] image_width;
      logic [11:0] image_height;
   } cfg_type;

   function automatic logic signed [COORD_W-1:0] sext16(input logic signed [15:0] v);
      return {{(COORD_W-16){v[15]}}, v};
   endfunction

   function automatic logic signed [COORD_W-1:0] add_span(input logic signed [15:0] base,
                                                        input logic [15:0] span);
      logic signed [COORD_W-1:0] ext;
      ext = signed'({{(COORD_W-16){1'b0}}, span});
      return sext16(base) + ext;
   endfunction

   function automatic logic [11:0] clamp_px(input logic signed [COORD_W-1:0] raw,
                                            input logic [11:0] lim);
      logic signed [COORD_W-1:0] lim16;
      lim16 = signed'({{(COORD_W-16){1'b0}}, lim, 4'b0000});
      if (raw <= 0) begin
         return 12'd0;
      end else if (raw >= lim16) begin
         return lim;
      end else begin
         return raw[15:4];
      end
   endfunction

endpackage

`default_nettype wire

### sv/snms_front.sv
// Front end: accepts candidates, writes the candidate store, counts and flags
// overflow, and queues one descriptor per frame. Depends on snms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snms_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [15:0]        req_box_left,
   input  logic signed [15:0]        req_box_top,
   input  logic [15:0]               req_box_width,
   input  logic [15:0]               req_box_height,
   input  logic [15:0]               req_confidence,
   input  logic [6:0]                req_class_index,
   input  logic                      req_final_candidate,
   output snms_pkg::mem_wr_type      mem_wr,
   output snms_pkg::queue_if_type    q_head,
   input  snms_pkg::back_status_type bstat
);

   logic [snms_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   snms_pkg::frame_desc_type    q_mem_ff [snms_pkg::QDEPTH];
   logic [snms_pkg::QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [snms_pkg::QCNT_W-1:0] qcnt_ff, qcnt_in;
   logic                        accept, room, push;
   snms_pkg::frame_desc_type    push_desc;

   assign busy   = (qcnt_ff != '0) || bstat.active;
   assign accept = start && !busy;
   assign room   = count_ff < snms_pkg::CNT_W'(snms_pkg::MAX_CAND);
   assign push   = accept && req_final_candidate;

   assign mem_wr.en             = accept && room;
   assign mem_wr.addr           = count_ff[snms_pkg::IDX_W-1:0];
   assign mem_wr.data.cls       = req_class_index;
   assign mem_wr.data.score     = req_confidence;
   assign mem_wr.data.left      = req_box_left;
   assign mem_wr.data.top       = req_box_top;
   assign mem_wr.data.width     = req_box_width;
   assign mem_wr.data.height    = req_box_height;

   assign push_desc.count    = count_ff + snms_pkg::CNT_W'(room);
   assign push_desc.overflow = ovf_ff | !room;

   assign q_head.valid = qcnt_ff != '0;
   assign q_head.desc  = q_mem_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (push) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (accept && room) begin
         count_in = count_ff + 1'b1;
      end else if (accept) begin
         ovf_in = 1'b1;
      end
      qcnt_in = qcnt_ff + snms_pkg::QCNT_W'(push) - snms_pkg::QCNT_W'(bstat.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         qcnt_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         qcnt_ff  <= qcnt_in;
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (bstat.pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

### sv/snms_back.sv
// Back end: candidate store, max-score selection scans, pipelined IoU
// suppression scans and result output register. Depends on snms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snms_back (
   input  logic                      clock,
   input  logic                      reset,
   input  snms_pkg::cfg_type         cfg,
   input  snms_pkg::mem_wr_type      mem_wr,
   input  snms_pkg::queue_if_type    q_head,
   output snms_pkg::back_status_type bstat,
   output logic                      rsp_valid,
   output logic [11:0]               rsp_left,
   output logic [11:0]               rsp_top,
   output logic [11:0]               rsp_right,
   output logic [11:0]               rsp_bottom,
   output logic [15:0]               rsp_kept_score,
   output logic [6:0]                rsp_kept_class,
   output logic                      rsp_last_result,
   output logic                      rsp_no_detection,
   output logic                      rsp_overflowed
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MAX    = 3'd1;
   localparam logic [2:0] ST_PICK   = 3'd2;
   localparam logic [2:0] ST_SUP    = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam int IDX_W = snms_pkg::IDX_W;
   localparam int CNT_W = snms_pkg::CNT_W;
   localparam int OCW   = snms_pkg::OUT_CNT_W;
   localparam int CW    = snms_pkg::COORD_W;

   snms_pkg::cand_type mem [snms_pkg::MAX_CAND];

   logic [2:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            n_ff, n_in, addr_ff, addr_in;
   logic                        ovf_ff, ovf_in;
   logic [snms_pkg::MAX_CAND-1:0] done_ff, done_in;
   logic                        best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   snms_pkg::cand_type          best_rec_ff, best_rec_in;
   logic                        pend_vld_ff, pend_vld_in;
   snms_pkg::cand_type          pend_rec_ff, pend_rec_in;
   logic [OCW-1:0]              emit_cnt_ff, emit_cnt_in;
   snms_pkg::cand_type          a_rec_ff;
   logic [33:0]                 a_area_ff;

   logic                        issue;
   logic [IDX_W-1:0]            issue_idx;
   logic                        rd_vld_ff, rd_done_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   snms_pkg::cand_type          rd_rec_ff;

   logic                        s1_v_ff, s2_v_ff, s3_v_ff;
   logic [IDX_W-1:0]            s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [16:0]                 s1_w_ff, s1_h_ff, s1_bw_ff, s1_bh_ff;
   logic [33:0]                 s2_inter_ff, s2_areab_ff, s3_inter_ff;
   logic [34:0]                 s3_uni_ff;
   logic [42:0]                 rhs;
   logic [42:0]                 lhs;
   logic                        over;

   logic signed [CW-1:0]        ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   logic signed [CW:0]          ow, oh;

   logic                        rsp_v_in, rsp_last_in, rsp_nodet_in;
   logic                        rsp_valid_ff, rsp_last_ff, rsp_nodet_ff, rsp_ovf_ff;
   logic [11:0]                 rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;
   logic [15:0]                 rsp_score_ff;
   logic [6:0]                  rsp_class_ff;

   assign issue     = ((state_ff == ST_MAX) || (state_ff == ST_SUP)) && (addr_ff < n_ff);
   assign issue_idx = addr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
      rd_rec_ff <= mem[issue_idx];
   end

   // IoU geometry of candidate under test against the selected box
   assign ax0 = snms_pkg::sext16(a_rec_ff.left);
   assign ay0 = snms_pkg::sext16(a_rec_ff.top);
   assign ax1 = snms_pkg::add_span(a_rec_ff.left, a_rec_ff.width);
   assign ay1 = snms_pkg::add_span(a_rec_ff.top, a_rec_ff.height);
   assign bx0 = snms_pkg::sext16(rd_rec_ff.left);
   assign by0 = snms_pkg::sext16(rd_rec_ff.top);
   assign bx1 = snms_pkg::add_span(rd_rec_ff.left, rd_rec_ff.width);
   assign by1 = snms_pkg::add_span(rd_rec_ff.top, rd_rec_ff.height);

   always_comb begin
      ow = (CW+1)'((ax1 < bx1) ? ax1 : bx1) - (CW+1)'((ax0 > bx0) ? ax0 : bx0)
           + (CW+1)'(16);
      oh = (CW+1)'((ay1 < by1) ? ay1 : by1) - (CW+1)'((ay0 > by0) ? ay0 : by0)
           + (CW+1)'(16);
   end

   assign rhs  = cfg.iou_threshold * s3_uni_ff;
   assign lhs  = {1'b0, s3_inter_ff, 8'h00};
   assign over = s3_v_ff && (s3_uni_ff != '0) && (lhs > rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         s1_v_ff   <= (state_ff == ST_SUP) && rd_vld_ff && !rd_done_ff
                      && (rd_rec_ff.cls == a_rec_ff.cls);
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
      end
      rd_done_ff  <= done_ff[issue_idx];
      rd_idx_ff   <= issue_idx;
      s1_idx_ff   <= rd_idx_ff;
      s1_w_ff     <= (ow > 0) ? ow[16:0] : 17'd0;
      s1_h_ff     <= (oh > 0) ? oh[16:0] : 17'd0;
      s1_bw_ff    <= {1'b0, rd_rec_ff.width} + 17'd16;
      s1_bh_ff    <= {1'b0, rd_rec_ff.height} + 17'd16;
      s2_idx_ff   <= s1_idx_ff;
      s2_inter_ff <= s1_w_ff * s1_h_ff;
      s2_areab_ff <= s1_bw_ff * s1_bh_ff;
      s3_idx_ff   <= s2_idx_ff;
      s3_inter_ff <= s2_inter_ff;
      s3_uni_ff   <= 35'(a_area_ff) + 35'(s2_areab_ff) - 35'(s2_inter_ff);
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      addr_in      = issue ? addr_ff + 1'b1 : addr_ff;
      done_in      = done_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_rec_in  = best_rec_ff;
      pend_vld_in  = pend_vld_ff;
      pend_rec_in  = pend_rec_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_v_in     = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_nodet_in = 1'b0;
      bstat.pop    = 1'b0;
      bstat.active = state_ff != ST_IDLE;

      if ((state_ff == ST_MAX) && rd_vld_ff && !rd_done_ff
          && (!best_vld_ff || (rd_rec_ff.score > best_rec_ff.score))) begin
         best_vld_in = 1'b1;
         best_idx_in = rd_idx_ff;
         best_rec_in = rd_rec_ff;
      end
      if (over) begin
         done_in[s3_idx_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               bstat.pop   = 1'b1;
               n_in        = q_head.desc.count;
               ovf_in      = q_head.desc.overflow;
               addr_in     = '0;
               best_vld_in = 1'b0;
               state_in    = ST_MAX;
            end
         end
         ST_MAX: begin
            if ((addr_ff == n_ff) && !rd_vld_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!best_vld_ff) begin
               state_in = ST_FINISH;
            end else begin
               done_in[best_idx_ff] = 1'b1;
               rsp_v_in    = pend_vld_ff;
               pend_vld_in = 1'b1;
               pend_rec_in = best_rec_ff;
               emit_cnt_in = emit_cnt_ff + 1'b1;
               best_vld_in = 1'b0;
               addr_in     = '0;
               if (emit_cnt_in == OCW'(snms_pkg::MAX_OUT)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SUP;
               end
            end
         end
         ST_SUP: begin
            if ((addr_ff == n_ff) && !rd_vld_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(s1_v_ff || s2_v_ff || s3_v_ff)) begin
               addr_in     = '0;
               best_vld_in = 1'b0;
               state_in    = ST_MAX;
            end
         end
         ST_FINISH: begin
            rsp_v_in     = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_nodet_in = !pend_vld_ff;
            done_in      = '0;
            pend_vld_in  = 1'b0;
            emit_cnt_in  = '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         addr_ff      <= '0;
         done_ff      <= '0;
         best_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         ovf_ff       <= ovf_in;
         addr_ff      <= addr_in;
         done_ff      <= done_in;
         best_vld_ff  <= best_vld_in;
         pend_vld_ff  <= pend_vld_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      pend_rec_ff <= pend_rec_in;
      if (state_ff == ST_PICK) begin
         a_rec_ff  <= best_rec_ff;
         a_area_ff <= ({1'b0, best_rec_ff.width} + 17'd16)
                      * ({1'b0, best_rec_ff.height} + 17'd16);
      end
      rsp_last_ff  <= rsp_last_in;
      rsp_nodet_ff <= rsp_nodet_in;
      rsp_ovf_ff   <= ovf_ff;
      if (rsp_nodet_in) begin
         rsp_left_ff   <= '0;
         rsp_top_ff    <= '0;
         rsp_right_ff  <= '0;
         rsp_bottom_ff <= '0;
         rsp_score_ff  <= '0;
         rsp_class_ff  <= '0;
      end else begin
         rsp_left_ff   <= snms_pkg::clamp_px(snms_pkg::sext16(pend_rec_ff.left),
                                             cfg.image_width);
         rsp_top_ff    <= snms_pkg::clamp_px(snms_pkg::sext16(pend_rec_ff.top),
                                             cfg.image_height);
         rsp_right_ff  <= snms_pkg::clamp_px(
                             snms_pkg::add_span(pend_rec_ff.left, pend_rec_ff.width),
                             cfg.image_width);
         rsp_bottom_ff <= snms_pkg::clamp_px(
                             snms_pkg::add_span(pend_rec_ff.top, pend_rec_ff.height),
                             cfg.image_height);
         rsp_score_ff  <= pend_rec_ff.score;
         rsp_class_ff  <= pend_rec_ff.cls;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left         = rsp_left_ff;
   assign rsp_top          = rsp_top_ff;
   assign rsp_right        = rsp_right_ff;
   assign rsp_bottom       = rsp_bottom_ff;
   assign rsp_kept_score   = rsp_score_ff;
   assign rsp_kept_class   = rsp_class_ff;
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_no_detection = rsp_nodet_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule

`default_nettype wire

### sv/score_sort_class_nms_unit.sv
// Top level of the per-class score sorted NMS unit: CSR block, front end and back end.
// Depends on snms_pkg, snms_front, snms_back and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "score_sort_class_nms_unit_assert.svh"

// Candidates load at one per cycle (start high, busy low). The transaction with
// req_final_candidate set closes the frame; busy then stays high while the frame
// is processed. Processing repeats, once per kept box, a full scan of the stored
// candidates to find the best remaining one and a second scan through a 3-stage
// IoU pipeline to suppress same-class overlaps; both scans go through the single
// read port of the candidate store. Processing stops at the 64-box output limit.
// Results come out one per strobe on rsp_valid and cannot be stalled; the last one
// carries rsp_last_result. CSR writes are always ready and take effect at the next
// cycle; write them only while busy is low.
module score_sort_class_nms_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [15:0]                 req_box_left,
   input  logic signed [15:0]                 req_box_top,
   input  logic [15:0]                        req_box_width,
   input  logic [15:0]                        req_box_height,
   input  logic [15:0]                        req_confidence,
   input  logic [6:0]                         req_class_index,
   input  logic                               req_final_candidate,
   output logic                               rsp_valid,
   output logic [11:0]                        rsp_left,
   output logic [11:0]                        rsp_top,
   output logic [11:0]                        rsp_right,
   output logic [11:0]                        rsp_bottom,
   output logic [15:0]                        rsp_kept_score,
   output logic [6:0]                         rsp_kept_class,
   output logic                               rsp_last_result,
   output logic                               rsp_no_detection,
   output logic                               rsp_overflowed,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [snms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [snms_pkg::CSR_DATA_W-1:0]    csr_data
);

   snms_pkg::cfg_type         cfg_ff;
   snms_pkg::mem_wr_type      mem_wr;
   snms_pkg::queue_if_type    q_head;
   snms_pkg::back_status_type bstat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.iou_threshold <= 8'd115;
         cfg_ff.image_width   <= 12'd640;
         cfg_ff.image_height  <= 12'd640;
      end else if (csr_valid) begin
         case (csr_index)
            snms_pkg::CSR_IOU_THRESHOLD: begin
               cfg_ff.iou_threshold <= csr_data[7:0];
            end
            snms_pkg::CSR_IMAGE_WIDTH: begin
               cfg_ff.image_width <= csr_data[11:0];
            end
            snms_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_ff.image_height <= csr_data[11:0];
            end
            default: begin
            end
         endcase
      end
   end

   snms_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_box_left        (req_box_left),
      .req_box_top         (req_box_top),
      .req_box_width       (req_box_width),
      .req_box_height      (req_box_height),
      .req_confidence      (req_confidence),
      .req_class_index     (req_class_index),
      .req_final_candidate (req_final_candidate),
      .mem_wr              (mem_wr),
      .q_head              (q_head),
      .bstat               (bstat)
   );

   snms_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .mem_wr           (mem_wr),
      .q_head           (q_head),
      .bstat            (bstat),
      .rsp_valid        (rsp_valid),
      .rsp_left         (rsp_left),
      .rsp_top          (rsp_top),
      .rsp_right        (rsp_right),
      .rsp_bottom       (rsp_bottom),
      .rsp_kept_score   (rsp_kept_score),
      .rsp_kept_class   (rsp_kept_class),
      .rsp_last_result  (rsp_last_result),
      .rsp_no_detection (rsp_no_detection),
      .rsp_overflowed   (rsp_overflowed)
   );

   `SNMS_ASSERT_NXT(a_final_sets_busy, clock, reset, start && !busy && req_final_candidate, busy)
   `SNMS_ASSERT_IMP(a_back_holds_busy, clock, reset, bstat.active, busy)
   `SNMS_ASSERT_IMP(a_nodet_is_last, clock, reset, rsp_valid && rsp_no_detection, rsp_last_result)
   `SNMS_ASSERT_IMP(a_no_write_while_busy, clock, reset, busy, !mem_wr.en)

endmodule

`default_nettype wire

### tb/sv/snms_checker.sv
// Checker for the score sort class NMS unit: watches the candidate, result and CSR channels,
// predicts the kept boxes of each frame and compares them field by field.
// Depends on snms_pkg.
`timescale 1ns / 1ps

module snms_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic signed [15:0]              req_box_left,
   input  logic signed [15:0]              req_box_top,
   input  logic [15:0]                     req_box_width,
   input  logic [15:0]                     req_box_height,
   input  logic [15:0]                     req_confidence,
   input  logic [6:0]                      req_class_index,
   input  logic                            req_final_candidate,
   input  logic                            rsp_valid,
   input  logic [11:0]                     rsp_left,
   input  logic [11:0]                     rsp_top,
   input  logic [11:0]                     rsp_right,
   input  logic [11:0]                     rsp_bottom,
   input  logic [15:0]                     rsp_kept_score,
   input  logic [6:0]                      rsp_kept_class,
   input  logic                            rsp_last_result,
   input  logic                            rsp_no_detection,
   input  logic                            rsp_overflowed,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [snms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [snms_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              errors,
   output int                              pending,
   output int                              boxes_checked
);

   typedef struct {
      logic [11:0] left, top, right, bottom;
      logic [15:0] score;
      logic [6:0]  cls;
      logic        last, none, ovf;
   } kept_box_type;

   kept_box_type       kept_q[$];
   snms_pkg::cand_type frame_boxes[snms_pkg::MAX_CAND];
   int                 order[snms_pkg::MAX_CAND];
   bit                 dropped[snms_pkg::MAX_CAND];
   int                 stored;
   bit                 overflow;
   snms_pkg::cfg_type  cfg;

   assign pending = kept_q.size();

   function automatic bit overlaps_too_much(snms_pkg::cand_type a, snms_pkg::cand_type b);
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, w, h, inter, uni;
      ax0 = longint'($signed(a.left));
      ay0 = longint'($signed(a.top));
      ax1 = ax0 + longint'(a.width);
      ay1 = ay0 + longint'(a.height);
      bx0 = longint'($signed(b.left));
      by0 = longint'($signed(b.top));
      bx1 = bx0 + longint'(b.width);
      by1 = by0 + longint'(b.height);
      w = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0) + 16;
      h = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0) + 16;
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      inter = w * h;
      uni = (ax1 - ax0 + 16) * (ay1 - ay0 + 16) + (bx1 - bx0 + 16) * (by1 - by0 + 16) - inter;
      if (uni <= 0) return 1'b0;
      return inter * 256 > longint'(cfg.iou_threshold) * uni;
   endfunction

   function automatic logic [11:0] to_pixel(longint raw, logic [11:0] lim);
      if (raw <= 0) return 12'd0;
      if (raw >= longint'(lim) * 16) return lim;
      return 12'(raw >>> 4);
   endfunction

   task automatic predict_frame();
      int i, j, key, emitted;
      snms_pkg::cand_type a;
      kept_box_type k;
      longint x0, y0;
      emitted = 0;
      for (i = 0; i < stored; i++) begin
         key = i;
         j = i;
         while (j > 0 && frame_boxes[order[j-1]].score < frame_boxes[key].score) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = key;
         dropped[i] = 1'b0;
      end
      for (i = 0; i < stored; i++) begin
         if (!dropped[i]) begin
            for (j = i + 1; j < stored; j++) begin
               if (!dropped[j] && frame_boxes[order[i]].cls == frame_boxes[order[j]].cls &&
                   overlaps_too_much(frame_boxes[order[i]], frame_boxes[order[j]]))
                  dropped[j] = 1'b1;
            end
         end
      end
      for (i = 0; i < stored && emitted < snms_pkg::MAX_OUT; i++) begin
         if (!dropped[i]) begin
            a = frame_boxes[order[i]];
            x0 = longint'($signed(a.left));
            y0 = longint'($signed(a.top));
            k.left   = to_pixel(x0, cfg.image_width);
            k.top    = to_pixel(y0, cfg.image_height);
            k.right  = to_pixel(x0 + longint'(a.width), cfg.image_width);
            k.bottom = to_pixel(y0 + longint'(a.height), cfg.image_height);
            k.score  = a.score;
            k.cls    = a.cls;
            k.last   = 1'b0;
            k.none   = 1'b0;
            k.ovf    = overflow;
            kept_q.insert(kept_q.size(), k);
            emitted++;
         end
      end
      if (emitted == 0) begin
         k = '{default: '0};
         k.none = 1'b1;
         k.ovf  = overflow;
         kept_q.insert(kept_q.size(), k);
      end
      kept_q[kept_q.size()-1].last = 1'b1;
   endtask

   task automatic compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      kept_box_type k;
      if (reset) begin
         errors = 0;
         boxes_checked = 0;
         stored = 0;
         overflow = 1'b0;
         cfg.iou_threshold = 8'd115;
         cfg.image_width = 12'd640;
         cfg.image_height = 12'd640;
         kept_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               snms_pkg::CSR_IOU_THRESHOLD: cfg.iou_threshold = csr_data[7:0];
               snms_pkg::CSR_IMAGE_WIDTH:   cfg.image_width = csr_data[11:0];
               snms_pkg::CSR_IMAGE_HEIGHT:  cfg.image_height = csr_data[11:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (kept_q.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               k = kept_q.pop_front();
               compare("left", 16'(k.left), 16'(rsp_left));
               compare("top", 16'(k.top), 16'(rsp_top));
               compare("right", 16'(k.right), 16'(rsp_right));
               compare("bottom", 16'(k.bottom), 16'(rsp_bottom));
               compare("kept_score", k.score, rsp_kept_score);
               compare("kept_class", 16'(k.cls), 16'(rsp_kept_class));
               compare("last_result", 16'(k.last), 16'(rsp_last_result));
               compare("no_detection", 16'(k.none), 16'(rsp_no_detection));
               compare("overflowed", 16'(k.ovf), 16'(rsp_overflowed));
               boxes_checked++;
            end
         end
         if (start && !busy) begin
            if (stored < snms_pkg::MAX_CAND) begin
               frame_boxes[stored] = '{cls: req_class_index, score: req_confidence,
                                       left: req_box_left, top: req_box_top,
                                       width: req_box_width, height: req_box_height};
               stored++;
            end else begin
               overflow = 1'b1;
            end
            if (req_final_candidate) begin
               predict_frame();
               stored = 0;
               overflow = 1'b0;
            end
         end
      end
   end

endmodule

### tb/sv/tb_score_sort_class_nms_unit.sv
// Testbench top for the score sort class NMS unit: clock, reset, candidate and CSR stimulus.
// Depends on snms_pkg, score_sort_class_nms_unit and snms_checker.
`timescale 1ns / 1ps

module tb_score_sort_class_nms_unit;

   localparam int QUIET_LIMIT = 200000;
   localparam logic [snms_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic signed [15:0]                req_box_left = '0;
   logic signed [15:0]                req_box_top = '0;
   logic [15:0]                       req_box_width = '0;
   logic [15:0]                       req_box_height = '0;
   logic [15:0]                       req_confidence = '0;
   logic [6:0]                        req_class_index = '0;
   logic                              req_final_candidate = 1'b0;
   logic                              rsp_valid;
   logic [11:0]                       rsp_left, rsp_top, rsp_right, rsp_bottom;
   logic [15:0]                       rsp_kept_score;
   logic [6:0]                        rsp_kept_class;
   logic                              rsp_last_result, rsp_no_detection, rsp_overflowed;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [snms_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [snms_pkg::CSR_DATA_W-1:0]   csr_data = '0;
   int                                errors, pending, boxes_checked;
   int                                sent = 0;
   int                                frames = 0;
   int                                quiet = 0;
   bit                                calm = 1'b0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   score_sort_class_nms_unit u_dut (.*);

   snms_checker u_checker (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_box(logic [15:0] l, logic [15:0] t, logic [15:0] w, logic [15:0] h,
                           logic [15:0] s, logic [6:0] c, logic f);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_box_left <= l;
      req_box_top <= t;
      req_box_width <= w;
      req_box_height <= h;
      req_confidence <= s;
      req_class_index <= c;
      req_final_candidate <= f;
      do @(posedge clock); while (busy);
      sent++;
      if (f) frames++;
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [snms_pkg::CSR_IDX_W-1:0] idx,
                            logic [snms_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [11:0] thr, logic [11:0] w, logic [11:0] h);
      settle();
      csr_write(snms_pkg::CSR_IOU_THRESHOLD, thr);
      csr_write(snms_pkg::CSR_IMAGE_WIDTH, w);
      csr_write(snms_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   // clustered boxes over a few classes so suppression really happens
   task automatic random_frame(int n);
      logic [15:0] bl, bt, bw, bh, tie;
      logic [6:0]  cls0;
      int i;
      bl = 16'($urandom_range(0, 700 * 16)) - 16'd800;
      bt = 16'($urandom_range(0, 700 * 16)) - 16'd800;
      bw = 16'($urandom_range(16, 200 * 16));
      bh = 16'($urandom_range(16, 200 * 16));
      cls0 = 7'($urandom_range(0, 127));
      tie = 16'($urandom);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 7'($urandom), i == n - 1);
         else
            send_box(bl + 16'($urandom_range(0, 512)), bt + 16'($urandom_range(0, 512)),
                     bw + 16'($urandom_range(0, 256)), bh + 16'($urandom_range(0, 256)),
                     ($urandom_range(0, 3) == 0) ? tie : 16'($urandom),
                     cls0 + 7'($urandom_range(0, 2)), i == n - 1);
      end
   endtask

   initial begin
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes, ties, out-of-range class, default config
      send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0, 1'b0);
      send_box(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 7'd79, 1'b0);
      send_box(16'd160, 16'd160, 16'd1600, 16'd1600, 16'd5000, 7'd127, 1'b0);
      send_box(16'd160, 16'd160, 16'd1600, 16'd1600, 16'd5000, 7'd3, 1'b0);
      send_box(16'd176, 16'd176, 16'd1600, 16'd1600, 16'd5000, 7'd3, 1'b0);
      send_box(16'd192, 16'd160, 16'd1600, 16'd1600, 16'd5000, 7'd4, 1'b0);
      send_box(16'd9000, 16'd9000, 16'd800, 16'd800, 16'd5000, 7'd3, 1'b1);
      send_box(16'd100, 16'd100, 16'd10000, 16'd9000, 16'd1234, 7'd10, 1'b1);
      set_config(12'hF00, 12'h000, 12'h000);
      send_box(16'd100, 16'd100, 16'd10000, 16'd9000, 16'd1234, 7'd10, 1'b0);
      send_box(16'd120, 16'd100, 16'd10000, 16'd9000, 16'd1233, 7'd10, 1'b1);
      set_config(12'hFFF, 12'hFFF, 12'hFFF);
      csr_write(CSR_UNUSED, 12'h5A5);
      send_box(16'd0, 16'd0, 16'd1600, 16'd1600, 16'd300, 7'd1, 1'b0);
      send_box(16'd0, 16'd0, 16'd1600, 16'd1600, 16'd300, 7'd1, 1'b0);
      send_box(16'hFFF0, 16'd16, 16'd16, 16'd16, 16'd299, 7'd1, 1'b1);

      // capacity overflow with the final candidate dropped, and more survivors
      // than the output limit
      set_config(12'd200, 12'd1, 12'd4095);
      for (i = 0; i < snms_pkg::MAX_CAND + 2; i++)
         send_box(16'(i * 64), 16'(i * 32), 16'd400, 16'd400, 16'($urandom),
                  7'(i % 80), i == snms_pkg::MAX_CAND + 1);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(12'd0, 12'd640, 12'd640);
            1: set_config(12'd255, 12'd4095, 12'd1);
            default: set_config(12'($urandom), 12'($urandom_range(1, 4095)),
                                12'($urandom_range(1, 4095)));
         endcase
         if (phase >= 4) calm = 1'b1;
         random_frame($urandom_range(1, 10));
      end

      settle();
      $display("Sent %0d candidates in %0d frames, checked %0d result boxes",
               sent, frames, boxes_checked);
      $display("Covered overflow, output limit, ties, odd classes and clamp extremes");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
